### sv/nearest_upscale_rotated_blit_macros.svh
// Assertion helpers for the verification files of the blit block.
`ifndef NEAREST_UPSCALE_ROTATED_BLIT_MACROS_SVH
`define NEAREST_UPSCALE_ROTATED_BLIT_MACROS_SVH

// Checked only outside reset.
`define NURB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define NURB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/nurb_pkg.sv
package nurb_pkg;

   localparam int SCREEN_WIDTH  = 400;
   localparam int SCREEN_HEIGHT = 240;
   localparam int MAX_SCALE     = 8;

   localparam int WIDTH_W  = 9;
   localparam int HEIGHT_W = 8;
   localparam int SCALE_W  = 4;
   localparam int SUB_W    = 3;
   localparam int RGB_W    = 24;
   localparam int ADDR_W   = 19;
   localparam int SX_W     = 9;    // saturated screen column, 0..399
   localparam int SY_W     = 8;    // saturated screen row, 0..239
   localparam int WS_W     = WIDTH_W + SCALE_W;
   localparam int HS_W     = HEIGHT_W + SCALE_W;

   localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = WIDTH_W'(200);
   localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = HEIGHT_W'(120);
   localparam logic [SCALE_W-1:0]  RESET_SCALE  = SCALE_W'(2);

   // Register indexes on the configuration port (byte address / 4).
   localparam logic [1:0] REG_RENDER_WIDTH  = 2'd0;
   localparam logic [1:0] REG_RENDER_HEIGHT = 2'd1;
   localparam logic [1:0] REG_SCALE_FACTOR  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_ORIGIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [WIDTH_W-1:0]  width;
      logic [HEIGHT_W-1:0] height;
      logic [SCALE_W-1:0]  scale;
   } cfg_type;

   typedef struct packed {
      logic load;        // take the input item, advance the source position
      logic calc_scale;  // image size and pixel position times scale
      logic calc_origin; // centering offsets and square origin
      logic emit;        // load one write into the output register
   } cmd_type;

   typedef struct packed {
      logic out_free;    // output register empty or being taken
      logic last_sub;    // replication counters at the last write
   } status_type;

endpackage

### sv/nearest_upscale_rotated_blit.sv
// Nearest-neighbor upscale blit: each input item is one source pixel in raster
// order, and the block answers with scale*scale result items, each a single
// pixel write (byte address of the blue byte plus blue, green and red bytes)
// into a 400x240 screen stored column-major with its rows reversed. The image
// is centered on the screen; last_of_pixel marks the final write of a pixel
// and last_of_frame the final write of the frame. Each item passes through
// the states that accept it, form the scaled position and then the
// centering offsets, and then loads one write per cycle into the output
// register while that register is free to take it.
// A new item is accepted as soon as the last write of the previous one sits
// in the output register. Software keeps width*scale <= 400 and
// height*scale <= 240; beyond that, writes clamp to the last screen column
// or row. Registers at byte addresses 0, 4 and 8 hold render_width,
// render_height and scale_factor and should only be written while idle.
module nearest_upscale_rotated_blit (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [nurb_pkg::RGB_W-1:0]  req_pixel_rgb,

   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [nurb_pkg::ADDR_W-1:0] rsp_write_offset,
   output logic [7:0]                  rsp_blue_byte,
   output logic [7:0]                  rsp_green_byte,
   output logic [7:0]                  rsp_red_byte,
   output logic                        rsp_last_of_pixel,
   output logic                        rsp_last_of_frame,

   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [3:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   // Configuration registers. The port never inserts wait states, so a write
   // lands on the access cycle of the transfer.
   nurb_pkg::cfg_type cfg_ff;
   logic              wr_en;
   logic [1:0]        reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   assign reg_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= nurb_pkg::RESET_WIDTH;
         cfg_ff.height <= nurb_pkg::RESET_HEIGHT;
         cfg_ff.scale  <= nurb_pkg::RESET_SCALE;
      end else if (wr_en) begin
         case (reg_index)
            nurb_pkg::REG_RENDER_WIDTH: begin
               cfg_ff.width <= pwdata[nurb_pkg::WIDTH_W-1:0];
            end
            nurb_pkg::REG_RENDER_HEIGHT: begin
               cfg_ff.height <= pwdata[nurb_pkg::HEIGHT_W-1:0];
            end
            nurb_pkg::REG_SCALE_FACTOR: begin
               cfg_ff.scale <= pwdata[nurb_pkg::SCALE_W-1:0];
            end
            default: begin
               // Addresses past the register list are ignored.
            end
         endcase
      end
   end

   // Reads return the stored value, zero-extended; unmapped addresses read 0.
   always_comb begin
      case (reg_index)
         nurb_pkg::REG_RENDER_WIDTH:  prdata = 32'(cfg_ff.width);
         nurb_pkg::REG_RENDER_HEIGHT: prdata = 32'(cfg_ff.height);
         nurb_pkg::REG_SCALE_FACTOR:  prdata = 32'(cfg_ff.scale);
         default:                     prdata = '0;
      endcase
   end

   // The controller sequences one item at a time; the datapath holds the
   // source position, the per-item arithmetic and the output register.
   nurb_pkg::cmd_type    cmd;
   nurb_pkg::status_type status;

   nurb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   nurb_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .cmd               (cmd),
      .status            (status),
      .req_pixel_rgb     (req_pixel_rgb),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_offset  (rsp_write_offset),
      .rsp_blue_byte     (rsp_blue_byte),
      .rsp_green_byte    (rsp_green_byte),
      .rsp_red_byte      (rsp_red_byte),
      .rsp_last_of_pixel (rsp_last_of_pixel),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

### sv/nurb_ctrl.sv
module nurb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  nurb_pkg::status_type status,
   output nurb_pkg::cmd_type    cmd
);

   nurb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nurb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         nurb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = nurb_pkg::ST_SCALE;
            end
         end
         nurb_pkg::ST_SCALE: begin
            cmd.calc_scale = 1'b1;
            state_in       = nurb_pkg::ST_ORIGIN;
         end
         nurb_pkg::ST_ORIGIN: begin
            cmd.calc_origin = 1'b1;
            state_in        = nurb_pkg::ST_EMIT;
         end
         nurb_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_sub) begin
                  state_in = nurb_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = nurb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### sv/nurb_datapath.sv
module nurb_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  nurb_pkg::cfg_type             cfg,
   input  nurb_pkg::cmd_type             cmd,
   output nurb_pkg::status_type          status,
   input  logic [nurb_pkg::RGB_W-1:0]    req_pixel_rgb,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [nurb_pkg::ADDR_W-1:0]   rsp_write_offset,
   output logic [7:0]                    rsp_blue_byte,
   output logic [7:0]                    rsp_green_byte,
   output logic [7:0]                    rsp_red_byte,
   output logic                          rsp_last_of_pixel,
   output logic                          rsp_last_of_frame
);

   localparam int WS_W = nurb_pkg::WS_W;
   localparam int HS_W = nurb_pkg::HS_W;
   localparam int SUB_W = nurb_pkg::SUB_W;

   // Effective configuration: zero sizes act as one, scale is clamped.
   logic [nurb_pkg::WIDTH_W-1:0]  w_eff;
   logic [nurb_pkg::HEIGHT_W-1:0] h_eff;
   logic [nurb_pkg::SCALE_W-1:0]  s_eff;
   logic [SUB_W-1:0]              s_m1;

   always_comb begin
      w_eff = (cfg.width == '0) ? nurb_pkg::WIDTH_W'(1) : cfg.width;
      h_eff = (cfg.height == '0) ? nurb_pkg::HEIGHT_W'(1) : cfg.height;
      if (cfg.scale == '0) begin
         s_eff = nurb_pkg::SCALE_W'(1);
      end else if (cfg.scale > nurb_pkg::SCALE_W'(nurb_pkg::MAX_SCALE)) begin
         s_eff = nurb_pkg::SCALE_W'(nurb_pkg::MAX_SCALE);
      end else begin
         s_eff = cfg.scale;
      end
      s_m1 = SUB_W'(s_eff - nurb_pkg::SCALE_W'(1));
   end

   // Source position of the next item and the latched item.
   logic [nurb_pkg::WIDTH_W-1:0]  col_ff, col_item_ff;
   logic [nurb_pkg::HEIGHT_W-1:0] row_ff, row_item_ff;
   logic [nurb_pkg::RGB_W-1:0]    pix_ff;
   logic                          frame_end_ff;
   logic                          row_end, frame_end;

   assign row_end   = ({1'b0, col_ff} + 1'b1) >= {1'b0, w_eff};
   assign frame_end = row_end && (({1'b0, row_ff} + 1'b1) >= {1'b0, h_eff});

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.load) begin
         if (row_end) begin
            col_ff <= '0;
            row_ff <= frame_end ? '0 : row_ff + 1'b1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pix_ff       <= req_pixel_rgb;
         col_item_ff  <= col_ff;
         row_item_ff  <= row_ff;
         frame_end_ff <= frame_end;
      end
   end

   // Scaled sizes and scaled position, then centering and square origin.
   logic [WS_W-1:0] ws_ff, cs_ff, sx0_ff;
   logic [HS_W-1:0] hs_ff, rs_ff, sy0_ff;
   logic [WS_W-1:0] left;
   logic [HS_W-1:0] top;

   always_comb begin
      if (ws_ff <= WS_W'(nurb_pkg::SCREEN_WIDTH)) begin
         left = (WS_W'(nurb_pkg::SCREEN_WIDTH) - ws_ff) >> 1;
      end else begin
         left = '0;
      end
      if (hs_ff <= HS_W'(nurb_pkg::SCREEN_HEIGHT)) begin
         top = (HS_W'(nurb_pkg::SCREEN_HEIGHT) - hs_ff) >> 1;
      end else begin
         top = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc_scale) begin
         ws_ff <= WS_W'(w_eff * s_eff);
         hs_ff <= HS_W'(h_eff * s_eff);
         cs_ff <= WS_W'(col_item_ff * s_eff);
         rs_ff <= HS_W'(row_item_ff * s_eff);
      end
      if (cmd.calc_origin) begin
         sx0_ff <= left + cs_ff;
         sy0_ff <= top + rs_ff;
      end
   end

   // Replication counters: sub-row outer, sub-column inner.
   logic [SUB_W-1:0] dx_ff, dy_ff;
   logic             last_col;

   assign last_col = (dx_ff == s_m1);

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         dx_ff <= '0;
         dy_ff <= '0;
      end else if (cmd.emit) begin
         if (last_col) begin
            dx_ff <= '0;
            dy_ff <= (dy_ff == s_m1) ? '0 : dy_ff + 1'b1;
         end else begin
            dx_ff <= dx_ff + 1'b1;
         end
      end
   end

   // Screen coordinate of this write, saturated to the screen, then address.
   logic [WS_W:0]                 sx_sum;
   logic [HS_W:0]                 sy_sum;
   logic [nurb_pkg::SX_W-1:0]     sx;
   logic [nurb_pkg::SY_W-1:0]     sy;
   logic [nurb_pkg::ADDR_W-1:0]   addr;

   always_comb begin
      sx_sum = {1'b0, sx0_ff} + (WS_W + 1)'(dx_ff);
      sy_sum = {1'b0, sy0_ff} + (HS_W + 1)'(dy_ff);
      if (sx_sum > (WS_W + 1)'(nurb_pkg::SCREEN_WIDTH - 1)) begin
         sx = nurb_pkg::SX_W'(nurb_pkg::SCREEN_WIDTH - 1);
      end else begin
         sx = sx_sum[nurb_pkg::SX_W-1:0];
      end
      if (sy_sum > (HS_W + 1)'(nurb_pkg::SCREEN_HEIGHT - 1)) begin
         sy = nurb_pkg::SY_W'(nurb_pkg::SCREEN_HEIGHT - 1);
      end else begin
         sy = sy_sum[nurb_pkg::SY_W-1:0];
      end
      addr = nurb_pkg::ADDR_W'(
         (nurb_pkg::ADDR_W'(sx) * nurb_pkg::ADDR_W'(nurb_pkg::SCREEN_HEIGHT)
          + nurb_pkg::ADDR_W'(nurb_pkg::SY_W'(nurb_pkg::SCREEN_HEIGHT - 1) - sy))
         * nurb_pkg::ADDR_W'(3));
   end

   // Output register.
   logic                        out_valid_ff;
   logic [nurb_pkg::ADDR_W-1:0] out_addr_ff;
   logic [7:0]                  out_blue_ff, out_green_ff, out_red_ff;
   logic                        out_lpix_ff, out_lframe_ff;
   logic                        last_write;

   assign last_write = last_col && (dy_ff == s_m1);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_addr_ff   <= addr;
         out_blue_ff   <= pix_ff[23:16];
         out_green_ff  <= pix_ff[15:8];
         out_red_ff    <= pix_ff[7:0];
         out_lpix_ff   <= last_write;
         out_lframe_ff <= last_write && frame_end_ff;
      end
   end

   assign status.out_free = !out_valid_ff || rsp_ready;
   assign status.last_sub = last_write;

   assign rsp_valid         = out_valid_ff;
   assign rsp_write_offset  = out_addr_ff;
   assign rsp_blue_byte     = out_blue_ff;
   assign rsp_green_byte    = out_green_ff;
   assign rsp_red_byte      = out_red_ff;
   assign rsp_last_of_pixel = out_lpix_ff;
   assign rsp_last_of_frame = out_lframe_ff;

endmodule

### sv/nurb_checker.sv
`include "nearest_upscale_rotated_blit_macros.svh"

module nurb_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [nurb_pkg::ADDR_W-1:0] rsp_write_offset,
   input logic                        rsp_last_of_pixel,
   input logic                        rsp_last_of_frame,
   input logic                        pready
);

   // A stalled write keeps its address and flags.
   `NURB_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_write_offset) && $stable(rsp_last_of_pixel) && $stable(rsp_last_of_frame), "stalled write changed")

   // The frame can only end on the last write of a pixel.
   `NURB_ASSERT(a_frame_on_pixel, clock, reset, rsp_valid && rsp_last_of_frame |-> rsp_last_of_pixel, "last_of_frame without last_of_pixel")

   // One item at a time: the cycle after an accept takes no new item.
   `NURB_ASSERT(a_one_item, clock, reset, req_valid && req_ready |=> !req_ready, "item accepted while busy")

   // Writes stay inside the framebuffer.
   `NURB_ASSERT(a_addr_range, clock, reset, rsp_valid |-> rsp_write_offset <= 19'd287997, "write outside framebuffer")

   // The configuration port never inserts wait states.
   `NURB_ASSERT_ALWAYS(a_pready, clock, pready, "pready low")

endmodule

bind nearest_upscale_rotated_blit nurb_checker u_nurb_checker (.*);

### bench/nearest_upscale_rotated_blit_tb.sv
module nearest_upscale_rotated_blit_tb;

   // One pixel write as the block should present it on the result channel.
   typedef struct packed {
      logic [nurb_pkg::ADDR_W-1:0] offset;
      logic [7:0]                  blue;
      logic [7:0]                  green;
      logic [7:0]                  red;
      logic                        last_pixel;
      logic                        last_frame;
   } pixel_write_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [nurb_pkg::RGB_W-1:0]    req_pixel_rgb = '0;

   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [nurb_pkg::ADDR_W-1:0]   rsp_write_offset;
   logic [7:0]                    rsp_blue_byte;
   logic [7:0]                    rsp_green_byte;
   logic [7:0]                    rsp_red_byte;
   logic                          rsp_last_of_pixel;
   logic                          rsp_last_of_frame;

   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [3:0]                    paddr = '0;
   logic [31:0]                   pwdata = '0;
   logic [31:0]                   prdata;
   logic                          pready;

   // Shadow copy of the geometry registers, updated as each write is set up.
   logic [nurb_pkg::WIDTH_W-1:0]  cur_width  = nurb_pkg::RESET_WIDTH;
   logic [nurb_pkg::HEIGHT_W-1:0] cur_height = nurb_pkg::RESET_HEIGHT;
   logic [nurb_pkg::SCALE_W-1:0]  cur_scale  = nurb_pkg::RESET_SCALE;

   // Source position of the next pixel, kept the same way the block does.
   int                            pos_column = 0;
   int                            pos_row = 0;

   // Writes predicted for accepted pixels, oldest first.
   pixel_write_type               pending_writes[$];

   int                            send_idle_pct = 0;
   int                            recv_idle_pct = 0;
   int                            rsp_hold_left = 0;
   int                            sent_count = 0;
   int                            mismatch_count = 0;

   nearest_upscale_rotated_blit u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   // Expands one source pixel into its scale-by-scale square of writes. The
   // effective scale is clamped to 1..MAX_SCALE and a zero size acts as one.
   // The image is centered, unless it is larger than the screen, in which case
   // that offset is zero and coordinates clamp to the last column or row. The
   // screen is column-major with rows reversed, three bytes per pixel.
   function automatic void predict_blit_writes(input logic [nurb_pkg::RGB_W-1:0] rgb);
      int              w;
      int              h;
      int              s;
      int              left;
      int              top;
      int              sx;
      int              sy;
      int              addr;
      bit              row_end;
      bit              frame_end;
      pixel_write_type wr;
      w = (cur_width == 0) ? 1 : int'(cur_width);
      h = (cur_height == 0) ? 1 : int'(cur_height);
      s = (cur_scale == 0) ? 1 : int'(cur_scale);
      if (s > nurb_pkg::MAX_SCALE) begin
         s = nurb_pkg::MAX_SCALE;
      end
      left = (w * s <= nurb_pkg::SCREEN_WIDTH) ? (nurb_pkg::SCREEN_WIDTH - w * s) / 2 : 0;
      top = (h * s <= nurb_pkg::SCREEN_HEIGHT) ? (nurb_pkg::SCREEN_HEIGHT - h * s) / 2 : 0;
      // A position already past a shrunken size still ends its row or frame.
      row_end = (pos_column + 1 >= w);
      frame_end = row_end && (pos_row + 1 >= h);
      for (int dy = 0; dy < s; dy++) begin
         sy = top + pos_row * s + dy;
         if (sy > nurb_pkg::SCREEN_HEIGHT - 1) begin
            sy = nurb_pkg::SCREEN_HEIGHT - 1;
         end
         for (int dx = 0; dx < s; dx++) begin
            sx = left + pos_column * s + dx;
            if (sx > nurb_pkg::SCREEN_WIDTH - 1) begin
               sx = nurb_pkg::SCREEN_WIDTH - 1;
            end
            addr = (sx * nurb_pkg::SCREEN_HEIGHT + (nurb_pkg::SCREEN_HEIGHT - 1 - sy)) * 3;
            wr.offset = addr[nurb_pkg::ADDR_W-1:0];
            wr.blue = rgb[23:16];
            wr.green = rgb[15:8];
            wr.red = rgb[7:0];
            wr.last_pixel = (dy == s - 1) && (dx == s - 1);
            wr.last_frame = wr.last_pixel && frame_end;
            pending_writes.push_back(wr);
         end
      end
      if (row_end) begin
         pos_column = 0;
         pos_row = frame_end ? 0 : ((pos_row + 1) & 8'hff);
      end else begin
         pos_column = (pos_column + 1) & 9'h1ff;
      end
   endfunction

   // Offers one pixel, after an optional random gap, and holds it until the
   // block takes it. Valid stays high when the next item follows at once.
   task automatic send_pixel(input logic [nurb_pkg::RGB_W-1:0] rgb);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_rgb <= rgb;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      predict_blit_writes(rgb);
      sent_count++;
   endtask

   task automatic send_random_pixels(input int count);
      repeat (count) send_pixel(nurb_pkg::RGB_W'($urandom_range(0, 24'hffffff)));
   endtask

   // The sender stops and waits for every predicted write to come out. Each
   // pixel causes at least one write, so an empty queue means the block is
   // idle and its output register empty; a short margin follows.
   task automatic wait_for_blit_idle();
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register is written at the edge that
   // ends the access. High bits above the register width carry noise.
   task automatic write_reg(input logic [1:0] index, input int unsigned value);
      logic [31:0] word;
      word = $urandom;
      case (index)
         nurb_pkg::REG_RENDER_WIDTH: begin
            word[nurb_pkg::WIDTH_W-1:0] = value[nurb_pkg::WIDTH_W-1:0];
            cur_width = value[nurb_pkg::WIDTH_W-1:0];
         end
         nurb_pkg::REG_RENDER_HEIGHT: begin
            word[nurb_pkg::HEIGHT_W-1:0] = value[nurb_pkg::HEIGHT_W-1:0];
            cur_height = value[nurb_pkg::HEIGHT_W-1:0];
         end
         default: begin
            word[nurb_pkg::SCALE_W-1:0] = value[nurb_pkg::SCALE_W-1:0];
            cur_scale = value[nurb_pkg::SCALE_W-1:0];
         end
      endcase
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {index, 2'b00};
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic set_geometry(input int unsigned w, input int unsigned h,
                               input int unsigned s);
      wait_for_blit_idle();
      write_reg(nurb_pkg::REG_RENDER_WIDTH, w);
      write_reg(nurb_pkg::REG_RENDER_HEIGHT, h);
      write_reg(nurb_pkg::REG_SCALE_FACTOR, s);
   endtask

   // Reset geometry is 200x120 at scale two, which fills the screen exactly.
   task automatic test_reset_defaults();
      send_pixel(24'h000000);
      send_pixel(24'hffffff);
      send_pixel(24'h3ca55a);
   endtask

   // One channel at a time, to catch swapped color bytes.
   task automatic test_color_channels();
      send_pixel(24'h0000ff);
      send_pixel(24'h00ff00);
      send_pixel(24'hff0000);
   endtask

   // The column is past the new width, so the next pixel ends its row. Then a
   // height below the current row makes the end of that row the frame end.
   task automatic test_mid_frame_resize();
      set_geometry(4, 3, 1);
      send_random_pixels(1);
      set_geometry(4, 1, 1);
      send_random_pixels(4);
      set_geometry(2, 2, 3);
      send_random_pixels(4);
   endtask

   // Zero and oversized scale, zero sizes, all register bits set, and an
   // image that exactly covers the screen at the largest legal size.
   task automatic test_scale_and_size_limits();
      set_geometry(3, 2, 0);
      send_random_pixels(1);
      set_geometry(3, 2, 15);
      send_random_pixels(1);
      set_geometry(3, 2, 9);
      send_random_pixels(1);
      set_geometry(0, 0, 1);
      send_random_pixels(2);
      set_geometry(511, 255, 8);
      send_random_pixels(1);
      set_geometry(400, 240, 1);
      send_random_pixels(1);
   endtask

   // The receiver stops for a long stretch while pixels keep coming, so the
   // block fills and has to hold off its input.
   task automatic test_output_backpressure();
      int saved_pct;
      saved_pct = send_idle_pct;
      set_geometry(8, 4, 2);
      send_idle_pct = 0;
      rsp_hold_left = 200;
      send_random_pixels(24);
      wait_for_blit_idle();
      send_idle_pct = saved_pct;
   endtask

   // Walks far enough down or across an oversized image that the screen
   // coordinates clamp to the last row or column.
   task automatic test_clamped_walks();
      set_geometry(1, $urandom_range(200, 255), $urandom_range(8, 15));
      send_random_pixels(36);
      set_geometry($urandom_range(60, 511), 1, $urandom_range(8, 15));
      send_random_pixels(56);
   endtask

   // One random geometry followed by a burst of pixels. Small images are
   // favored so that whole frames complete often; the position carries over
   // from the previous phase, which also exercises resizing mid-frame.
   task automatic run_random_phase();
      int w;
      int h;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            w = $urandom_range(1, 5);
            h = $urandom_range(1, 4);
            set_geometry(w, h, $urandom_range(1, 3));
            send_random_pixels(w * h * $urandom_range(1, 2) + $urandom_range(0, 2));
         end
         6: begin
            set_geometry($urandom_range(40, 200), $urandom_range(20, 120),
                         $urandom_range(1, 2));
            send_random_pixels($urandom_range(5, 20));
         end
         7: begin
            set_geometry($urandom_range(1, 4), $urandom_range(1, 3),
                         ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(9, 15));
            send_random_pixels($urandom_range(2, 6));
         end
         8: begin
            set_geometry($urandom_range(200, 511), $urandom_range(100, 255),
                         $urandom_range(2, 8));
            send_random_pixels($urandom_range(2, 6));
         end
         default: begin
            set_geometry(($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 3),
                         ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 3),
                         $urandom_range(1, 3));
            send_random_pixels($urandom_range(3, 8));
         end
      endcase
   endtask

   task automatic test_random_traffic(input int target_count);
      while (sent_count < target_count) run_random_phase();
   endtask

   // Result side: random stalls, or a long counted hold when one is requested.
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Every accepted write is matched against the oldest prediction.
   always @(posedge clock) begin
      pixel_write_type exp_wr;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_writes.size() == 0) begin
            report_mismatch($sformatf("unexpected write at offset %0d", rsp_write_offset));
         end else begin
            exp_wr = pending_writes.pop_front();
            if (rsp_write_offset !== exp_wr.offset) begin
               report_mismatch($sformatf("write_offset %0d, expected %0d",
                                         rsp_write_offset, exp_wr.offset));
            end
            if (rsp_blue_byte !== exp_wr.blue) begin
               report_mismatch($sformatf("blue_byte %h, expected %h",
                                         rsp_blue_byte, exp_wr.blue));
            end
            if (rsp_green_byte !== exp_wr.green) begin
               report_mismatch($sformatf("green_byte %h, expected %h",
                                         rsp_green_byte, exp_wr.green));
            end
            if (rsp_red_byte !== exp_wr.red) begin
               report_mismatch($sformatf("red_byte %h, expected %h",
                                         rsp_red_byte, exp_wr.red));
            end
            if (rsp_last_of_pixel !== exp_wr.last_pixel) begin
               report_mismatch($sformatf("last_of_pixel %b, expected %b",
                                         rsp_last_of_pixel, exp_wr.last_pixel));
            end
            if (rsp_last_of_frame !== exp_wr.last_frame) begin
               report_mismatch($sformatf("last_of_frame %b, expected %b",
                                         rsp_last_of_frame, exp_wr.last_frame));
            end
         end
      end
   end

   // The slowest correct run ends long before this watchdog fires; it then
   // reports a failure and stops.
   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A third of the pixels come after a gap; the receiver stalls about half.
      send_idle_pct = 33;
      recv_idle_pct = 51;
      test_reset_defaults();
      test_color_channels();
      test_mid_frame_resize();
      test_scale_and_size_limits();
      test_output_backpressure();
      test_clamped_walks();
      test_random_traffic(180);

      // Roles swapped.
      send_idle_pct = 51;
      recv_idle_pct = 33;
      test_random_traffic(290);

      // Full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(400);

      wait_for_blit_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_writes.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
